### hw/rtl/mbs_pkg.sv
// shared types, constants and defaults of the mime boundary scanner
package mbs_pkg;

    // parameter defaults
    localparam int BOUNDARY_MAX_DEF   = 16;
    localparam int MAX_BODY_BYTES_DEF = 65536;

    // fixed field widths
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int OFS_W    = 17;
    localparam int CFG_W    = 64;
    localparam int LEN_W    = 5;
    localparam int IDX_W    = 2;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_BOUNDARY_LOW  = 2'd0;
    localparam logic [IDX_W-1:0] REG_BOUNDARY_HIGH = 2'd1;
    localparam logic [IDX_W-1:0] REG_BOUNDARY_LEN  = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_NONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PART    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CLOSING = 2'd2;

    // special characters
    localparam logic [BYTE_W-1:0] CH_CR = 8'h0d;
    localparam logic [BYTE_W-1:0] CH_LF = 8'h0a;
    localparam logic [BYTE_W-1:0] CH_HY = 8'h2d;

    // boundary configuration seen by the scanner
    typedef struct packed {
        logic [CFG_W-1:0] boundary_low_bytes;
        logic [CFG_W-1:0] boundary_high_bytes;
        logic [LEN_W-1:0] boundary_length;
    } cfg_t;

    // one result beat
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OFS_W-1:0]    delim_start;
        logic [OFS_W-1:0]    delim_end;
    } result_t;

endpackage

### hw/rtl/mbs_body_if.sv
// body byte channel: valid/ready with one byte and an end-of-body flag
interface mbs_body_if;
    logic                           valid;
    logic                           ready;
    logic [mbs_pkg::BYTE_W-1:0]     data_byte;
    logic                           last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

### hw/rtl/mbs_result_if.sv
// result channel: valid/ready with status and delimiter offsets
interface mbs_result_if;
    logic                           valid;
    logic                           ready;
    logic [mbs_pkg::STATUS_W-1:0]   status;
    logic [mbs_pkg::OFS_W-1:0]      delim_start;
    logic [mbs_pkg::OFS_W-1:0]      delim_end;

    modport source (output valid, output status, output delim_start, output delim_end,
                    input ready);
    modport sink (input valid, input status, input delim_start, input delim_end,
                  output ready);
endinterface

### hw/rtl/mbs_cfg_regs.sv
// boundary configuration registers behind a plain write port
module mbs_cfg_regs
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [mbs_pkg::IDX_W-1:0]   cfg_index,
    input  logic [mbs_pkg::CFG_W-1:0]   cfg_data,
    output mbs_pkg::cfg_t               cfg
);

    logic [mbs_pkg::CFG_W-1:0] low_reg;
    logic [mbs_pkg::CFG_W-1:0] high_reg;
    logic [mbs_pkg::LEN_W-1:0] len_reg;

    // register writes, unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= '0;
            high_reg <= '0;
            len_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mbs_pkg::REG_BOUNDARY_LOW:  low_reg  <= cfg_data;
                mbs_pkg::REG_BOUNDARY_HIGH: high_reg <= cfg_data;
                mbs_pkg::REG_BOUNDARY_LEN:  len_reg  <= cfg_data[mbs_pkg::LEN_W-1:0];
                default:                    len_reg  <= len_reg;
            endcase
        end
    end

    assign cfg.boundary_low_bytes  = low_reg;
    assign cfg.boundary_high_bytes = high_reg;
    assign cfg.boundary_length     = len_reg;

endmodule

### hw/rtl/mbs_scan_core.sv
// delimiter search state machine, one byte per accepted beat
module mbs_scan_core
#(
    parameter int BOUNDARY_MAX   = mbs_pkg::BOUNDARY_MAX_DEF,
    parameter int MAX_BODY_BYTES = mbs_pkg::MAX_BODY_BYTES_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [mbs_pkg::BYTE_W-1:0]  data_byte,
    input  logic                        last_byte,
    input  mbs_pkg::cfg_t               cfg,
    output logic                        emit,
    output mbs_pkg::result_t            result
);

    localparam int POS_W = $clog2(MAX_BODY_BYTES + 1);
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_BODY_BYTES);
    localparam logic [mbs_pkg::LEN_W-1:0] BMAX = mbs_pkg::LEN_W'(BOUNDARY_MAX);

    typedef enum logic [3:0] {
        PH_START,
        PH_CR,
        PH_LF,
        PH_HYPHEN,
        PH_BOUNDARY,
        PH_HYPHEN2,
        PH_HYPHEN3,
        PH_CR2,
        PH_LF2
    } phase_t;

    phase_t                     phase_reg, phase_next;
    logic [mbs_pkg::LEN_W-1:0]  index_reg, index_next;
    logic                       closing_reg, closing_next;
    logic                       first_reg, first_next;
    logic [POS_W-1:0]           pos_reg, pos_next;
    logic [POS_W-1:0]           start_reg, start_next;

    phase_t                     ph_in;
    phase_t                     ph_new;
    logic [mbs_pkg::LEN_W-1:0]  idx_new;
    logic [mbs_pkg::LEN_W-1:0]  idx_inc;
    logic                       clos_new;
    logic [POS_W-1:0]           start_new;
    logic                       matched;
    logic                       tail_cut;
    logic [POS_W-1:0]           pos_inc;
    logic [mbs_pkg::LEN_W-1:0]  eff_len;
    logic [2*mbs_pkg::CFG_W-1:0] bnd_bytes;
    logic [mbs_pkg::BYTE_W-1:0] bnd_char;

    // clamp length, pick the expected boundary character
    assign eff_len   = (cfg.boundary_length > BMAX) ? BMAX : cfg.boundary_length;
    assign bnd_bytes = {cfg.boundary_high_bytes, cfg.boundary_low_bytes};
    assign bnd_char  = bnd_bytes[{index_reg[3:0], 3'b000} +: mbs_pkg::BYTE_W];
    assign idx_inc   = index_reg + 1'b1;

    // saturating position of the following byte
    assign pos_inc = (pos_reg == MAX_POS) ? MAX_POS : pos_reg + 1'b1;

    // one transition of the search
    always_comb
    begin
        ph_in = (first_reg && data_byte == mbs_pkg::CH_HY) ? PH_LF : phase_reg;
        ph_new    = PH_START;
        idx_new   = '0;
        clos_new  = 1'b0;
        start_new = start_reg;
        matched   = 1'b0;
        case (ph_in)
            PH_CR:
            begin
                if (data_byte == mbs_pkg::CH_LF)
                begin
                    ph_new   = PH_LF;
                    idx_new  = index_reg;
                    clos_new = closing_reg;
                end
            end
            PH_LF:
            begin
                if (data_byte == mbs_pkg::CH_HY)
                begin
                    ph_new   = PH_HYPHEN;
                    idx_new  = index_reg;
                    clos_new = closing_reg;
                end
                else if (data_byte == mbs_pkg::CH_CR)
                begin
                    ph_new    = PH_CR;
                    idx_new   = index_reg;
                    clos_new  = closing_reg;
                    start_new = pos_reg;
                end
            end
            PH_HYPHEN:
            begin
                if (data_byte == mbs_pkg::CH_HY)
                begin
                    ph_new   = PH_BOUNDARY;
                    clos_new = closing_reg;
                end
            end
            PH_BOUNDARY:
            begin
                if (eff_len != '0 && index_reg < eff_len && data_byte == bnd_char)
                begin
                    idx_new  = idx_inc;
                    clos_new = closing_reg;
                    ph_new   = (idx_inc == eff_len) ? PH_HYPHEN2 : PH_BOUNDARY;
                end
            end
            PH_HYPHEN2:
            begin
                if (data_byte == mbs_pkg::CH_HY)
                begin
                    ph_new   = PH_HYPHEN3;
                    idx_new  = index_reg;
                    clos_new = 1'b1;
                end
                else if (data_byte == mbs_pkg::CH_CR)
                begin
                    ph_new   = PH_LF2;
                    idx_new  = index_reg;
                    clos_new = closing_reg;
                end
            end
            PH_HYPHEN3:
            begin
                if (data_byte == mbs_pkg::CH_HY)
                begin
                    ph_new   = PH_CR2;
                    idx_new  = index_reg;
                    clos_new = closing_reg;
                end
            end
            PH_CR2:
            begin
                if (data_byte == mbs_pkg::CH_CR)
                begin
                    ph_new   = PH_LF2;
                    idx_new  = index_reg;
                    clos_new = closing_reg;
                end
            end
            PH_LF2:
            begin
                if (data_byte == mbs_pkg::CH_LF)
                begin
                    matched  = 1'b1;
                    ph_new   = PH_LF2;
                    idx_new  = index_reg;
                    clos_new = closing_reg;
                end
            end
            default:
            begin
                if (data_byte == mbs_pkg::CH_CR)
                begin
                    ph_new    = PH_CR;
                    idx_new   = index_reg;
                    clos_new  = closing_reg;
                    start_new = pos_reg;
                end
            end
        endcase
    end

    // delimiter cut off by the end of the body
    assign tail_cut = last_byte &&
                      (ph_new == PH_HYPHEN3 || ph_new == PH_CR2 || ph_new == PH_LF2);

    // result of this byte
    always_comb
    begin
        emit               = last_byte || matched;
        result.delim_start = mbs_pkg::OFS_W'(start_new);
        result.delim_end   = mbs_pkg::OFS_W'(pos_inc);
        if (matched || tail_cut)
            result.status = clos_new ? mbs_pkg::ST_CLOSING : mbs_pkg::ST_PART;
        else
            result.status = mbs_pkg::ST_NONE;
    end

    // next state, restart after any report
    always_comb
    begin
        phase_next   = phase_reg;
        index_next   = index_reg;
        closing_next = closing_reg;
        first_next   = first_reg;
        pos_next     = pos_reg;
        start_next   = start_reg;
        if (step)
        begin
            if (emit)
            begin
                phase_next   = PH_START;
                index_next   = '0;
                closing_next = 1'b0;
                first_next   = 1'b1;
                pos_next     = last_byte ? '0 : pos_inc;
                start_next   = last_byte ? '0 : pos_inc;
            end
            else
            begin
                phase_next   = ph_new;
                index_next   = idx_new;
                closing_next = clos_new;
                first_next   = 1'b0;
                pos_next     = pos_inc;
                start_next   = start_new;
            end
        end
    end

    // search state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_START;
            index_reg   <= '0;
            closing_reg <= 1'b0;
            first_reg   <= 1'b1;
            pos_reg     <= '0;
            start_reg   <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            index_reg   <= index_next;
            closing_reg <= closing_next;
            first_reg   <= first_next;
            pos_reg     <= pos_next;
            start_reg   <= start_next;
        end
    end

endmodule

### hw/rtl/mbs_out_queue.sv
// two-entry result queue between the scanner and the result channel
module mbs_out_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mbs_pkg::result_t    push_data,
    output logic                has_room,
    output logic                out_valid,
    input  logic                out_ready,
    output mbs_pkg::result_t    out_data
);

    mbs_pkg::result_t   entry_reg [2];
    logic               wr_ptr_reg, wr_ptr_next;
    logic               rd_ptr_reg, rd_ptr_next;
    logic [1:0]         count_reg, count_next;
    logic               pop;

    assign has_room  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

### hw/rtl/mime_boundary_scanner.sv
// top level of the mime multipart boundary scanner
//
//   channel   direction  beat contents
//   body      in         data_byte, last_byte
//   result    out        status, delim_start, delim_end
//   cfg_*     in         write enable, register index, 64-bit data
//
// one body byte per cycle; each byte is a single transition of the search
// state machine and at most one result beat comes out of it.
// results sit in a two-entry queue, so bytes keep flowing while one result
// waits; body.ready drops only when both entries are full.
// reset clears the search, the body position, the queue and the boundary.
module mime_boundary_scanner
#(
    parameter int BOUNDARY_MAX   = mbs_pkg::BOUNDARY_MAX_DEF,
    parameter int MAX_BODY_BYTES = mbs_pkg::MAX_BODY_BYTES_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    mbs_body_if.sink                    body,
    mbs_result_if.source                result,
    input  logic                        cfg_we,
    input  logic [mbs_pkg::IDX_W-1:0]   cfg_index,
    input  logic [mbs_pkg::CFG_W-1:0]   cfg_data
);

    mbs_pkg::cfg_t      cfg;
    mbs_pkg::result_t   scan_result;
    mbs_pkg::result_t   queue_head;
    logic               accept;
    logic               emit;
    logic               has_room;

    mbs_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // input handshake
    assign body.ready = has_room;
    assign accept     = body.valid && has_room;

    mbs_scan_core
    #(
        .BOUNDARY_MAX   (BOUNDARY_MAX),
        .MAX_BODY_BYTES (MAX_BODY_BYTES)
    )
    u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (accept),
        .data_byte (body.data_byte),
        .last_byte (body.last_byte),
        .cfg       (cfg),
        .emit      (emit),
        .result    (scan_result)
    );

    mbs_out_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && emit),
        .push_data (scan_result),
        .has_room  (has_room),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_data  (queue_head)
    );

    // result beat payload
    assign result.status      = queue_head.status;
    assign result.delim_start = queue_head.delim_start;
    assign result.delim_end   = queue_head.delim_end;

endmodule

### tb/mime_boundary_scanner_test.sv
// self-checking testbench for the mime multipart boundary scanner
module mime_boundary_scanner_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned BODY_LIMIT   = mbs_pkg::MAX_BODY_BYTES_DEF;
    localparam int unsigned BND_LIMIT    = mbs_pkg::BOUNDARY_MAX_DEF;
    localparam int          PHASE_BYTES  = 140;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          HOLD_CYCLES  = 200;
    localparam int          DRAIN_LIMIT  = 20000;

    // search phases of the delimiter state machine
    typedef enum logic [3:0] {
        SP_START,
        SP_CR,
        SP_LF,
        SP_HYPHEN,
        SP_BOUNDARY,
        SP_HYPHEN2,
        SP_HYPHEN3,
        SP_CR2,
        SP_LF2
    } scan_phase_t;

    typedef struct packed {
        logic [mbs_pkg::BYTE_W-1:0] data_byte;
        logic                       last_byte;
    } body_beat_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                      cfg_we;
    logic [mbs_pkg::IDX_W-1:0] cfg_index;
    logic [mbs_pkg::CFG_W-1:0] cfg_data;

    mbs_body_if   body_ch ();
    mbs_result_if res_ch ();

    mime_boundary_scanner dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .body      (body_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // bytes waiting to be sent and delimiter reports waiting to arrive
    body_beat_t        pending_bytes[$];
    mbs_pkg::result_t  expected_reports[$];

    // idling controls, set per phase
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // long receiver hold-off
    bit hold_go  = 1'b0;
    bit hold_ack = 1'b0;
    int hold_left = 0;

    logic byte_taken = 1'b0;

    // scanner copy: configuration
    logic [mbs_pkg::CFG_W-1:0] bnd_low  = '0;
    logic [mbs_pkg::CFG_W-1:0] bnd_high = '0;
    logic [mbs_pkg::LEN_W-1:0] bnd_len  = '0;

    // scanner copy: search state
    scan_phase_t                sc_phase   = SP_START;
    logic [mbs_pkg::LEN_W-1:0]  sc_index   = '0;
    logic                       sc_closing = 1'b0;
    logic                       sc_first   = 1'b1;
    int unsigned                sc_pos     = 0;
    logic [mbs_pkg::OFS_W-1:0]  sc_start   = '0;

    // boundary as the stimulus generator sees it
    logic [mbs_pkg::CFG_W-1:0]  gen_low  = '0;
    logic [mbs_pkg::CFG_W-1:0]  gen_high = '0;
    int                         gen_len  = 0;
    logic [mbs_pkg::BYTE_W-1:0] delim_buf[$];
    logic [mbs_pkg::BYTE_W-1:0] body_buf[$];

    // run statistics
    int err_count   = 0;
    int byte_count  = 0;
    int body_count  = 0;
    int part_count  = 0;
    int close_count = 0;
    int none_count  = 0;

    // mismatch: back to hunting for CR
    task fall_back();
        sc_phase   = SP_START;
        sc_index   = '0;
        sc_closing = 1'b0;
    endtask

    task restart_search(input int unsigned from);
        fall_back();
        sc_first = 1'b1;
        sc_start = (from > BODY_LIMIT) ? BODY_LIMIT[mbs_pkg::OFS_W-1:0]
                                       : from[mbs_pkg::OFS_W-1:0];
    endtask

    // one body byte through the scanner copy; queues any report it causes
    task automatic scan_byte(input logic [mbs_pkg::BYTE_W-1:0] c, input logic last);
        int unsigned pos;
        int unsigned nxt;
        int unsigned blen;
        logic [2*mbs_pkg::CFG_W-1:0] bw;
        logic hit;
        mbs_pkg::result_t rep;
        pos  = (sc_pos > BODY_LIMIT) ? BODY_LIMIT : sc_pos;
        nxt  = (pos + 1 > BODY_LIMIT) ? BODY_LIMIT : pos + 1;
        blen = (bnd_len > BND_LIMIT) ? BND_LIMIT : bnd_len;
        bw   = {bnd_high, bnd_low} >> (8 * sc_index[3:0]);
        hit  = 1'b0;

        // leading hyphen acts as if CR LF came first
        if (sc_first && c == mbs_pkg::CH_HY)
            sc_phase = SP_LF;
        sc_first = 1'b0;

        case (sc_phase)
            SP_CR:
                if (c == mbs_pkg::CH_LF) sc_phase = SP_LF; else fall_back();
            SP_LF:
                if (c == mbs_pkg::CH_HY)
                    sc_phase = SP_HYPHEN;
                else if (c == mbs_pkg::CH_CR)
                begin
                    sc_start = pos[mbs_pkg::OFS_W-1:0];
                    sc_phase = SP_CR;
                end
                else
                    fall_back();
            SP_HYPHEN:
                if (c == mbs_pkg::CH_HY)
                begin
                    sc_phase = SP_BOUNDARY;
                    sc_index = '0;
                end
                else
                    fall_back();
            SP_BOUNDARY:
                if (blen != 0 && sc_index < blen && c == bw[mbs_pkg::BYTE_W-1:0])
                begin
                    sc_index = sc_index + 1'b1;
                    if (sc_index == blen)
                        sc_phase = SP_HYPHEN2;
                end
                else
                    fall_back();
            SP_HYPHEN2:
                if (c == mbs_pkg::CH_HY)
                begin
                    sc_closing = 1'b1;
                    sc_phase   = SP_HYPHEN3;
                end
                else if (c == mbs_pkg::CH_CR)
                    sc_phase = SP_LF2;
                else
                    fall_back();
            SP_HYPHEN3:
                if (c == mbs_pkg::CH_HY) sc_phase = SP_CR2; else fall_back();
            SP_CR2:
                if (c == mbs_pkg::CH_CR) sc_phase = SP_LF2; else fall_back();
            SP_LF2:
                if (c == mbs_pkg::CH_LF) hit = 1'b1; else fall_back();
            default:
                if (c == mbs_pkg::CH_CR)
                begin
                    sc_start = pos[mbs_pkg::OFS_W-1:0];
                    sc_phase = SP_CR;
                end
                else
                    fall_back();
        endcase

        sc_pos = nxt;

        // complete delimiter, or one cut off by the end of the body
        if (hit || (last && (sc_phase == SP_HYPHEN3 || sc_phase == SP_CR2 ||
                             sc_phase == SP_LF2)))
        begin
            rep.status      = sc_closing ? mbs_pkg::ST_CLOSING : mbs_pkg::ST_PART;
            rep.delim_start = sc_start;
            rep.delim_end   = nxt[mbs_pkg::OFS_W-1:0];
            expected_reports.insert(expected_reports.size(), rep);
            if (last)
            begin
                sc_pos = 0;
                restart_search(0);
            end
            else
                restart_search(nxt);
        end
        else if (last)
        begin
            rep.status      = mbs_pkg::ST_NONE;
            rep.delim_start = sc_start;
            rep.delim_end   = nxt[mbs_pkg::OFS_W-1:0];
            expected_reports.insert(expected_reports.size(), rep);
            sc_pos = 0;
            restart_search(0);
        end
    endtask

    // sample both channels and the register port
    always @(posedge clk)
    begin
        mbs_pkg::result_t exp_rep;
        byte_taken <= body_ch.valid && body_ch.ready;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    mbs_pkg::REG_BOUNDARY_LOW:  bnd_low  = cfg_data;
                    mbs_pkg::REG_BOUNDARY_HIGH: bnd_high = cfg_data;
                    mbs_pkg::REG_BOUNDARY_LEN:  bnd_len  = cfg_data[mbs_pkg::LEN_W-1:0];
                    default: ;
                endcase
            end
            if (body_ch.valid && body_ch.ready)
            begin
                byte_count++;
                if (body_ch.last_byte)
                    body_count++;
                scan_byte(body_ch.data_byte, body_ch.last_byte);
            end
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("unexpected result beat: status %0d start %0d end %0d",
                           res_ch.status, res_ch.delim_start, res_ch.delim_end);
                    err_count++;
                end
                else
                begin
                    exp_rep = expected_reports[0];
                    expected_reports.delete(0);
                    case (exp_rep.status)
                        mbs_pkg::ST_PART:    part_count++;
                        mbs_pkg::ST_CLOSING: close_count++;
                        default:             none_count++;
                    endcase
                    if (res_ch.status !== exp_rep.status)
                    begin
                        $error("status: expected %0d, actual %0d",
                               exp_rep.status, res_ch.status);
                        err_count++;
                    end
                    if (res_ch.delim_start !== exp_rep.delim_start)
                    begin
                        $error("delim_start: expected %0d, actual %0d",
                               exp_rep.delim_start, res_ch.delim_start);
                        err_count++;
                    end
                    if (res_ch.delim_end !== exp_rep.delim_end)
                    begin
                        $error("delim_end: expected %0d, actual %0d",
                               exp_rep.delim_end, res_ch.delim_end);
                        err_count++;
                    end
                end
            end
        end
    end

    // body driver: holds a beat until taken, idles at random
    always @(negedge clk)
    begin
        body_beat_t nb;
        if (!rst_n)
            body_ch.valid <= 1'b0;
        else if (!body_ch.valid || byte_taken)
        begin
            if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                nb = pending_bytes[0];
                pending_bytes.delete(0);
                body_ch.valid     <= 1'b1;
                body_ch.data_byte <= nb.data_byte;
                body_ch.last_byte <= nb.last_byte;
            end
            else
                body_ch.valid <= 1'b0;
        end
    end

    // long hold-off counter
    always @(negedge clk)
    begin
        if (hold_go != hold_ack)
        begin
            hold_left <= HOLD_CYCLES;
            hold_ack  <= hold_go;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // result receiver with random stalls
    always @(negedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
            res_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task write_reg(input logic [mbs_pkg::IDX_W-1:0] idx,
                   input logic [mbs_pkg::CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task set_length(input logic [mbs_pkg::CFG_W-1:0] val);
        write_reg(mbs_pkg::REG_BOUNDARY_LEN, val);
        gen_len = (val[mbs_pkg::LEN_W-1:0] > BND_LIMIT) ? BND_LIMIT
                                                        : val[mbs_pkg::LEN_W-1:0];
    endtask

    task set_boundary(input logic [mbs_pkg::CFG_W-1:0] lo,
                      input logic [mbs_pkg::CFG_W-1:0] hi,
                      input logic [mbs_pkg::CFG_W-1:0] len_word);
        write_reg(mbs_pkg::REG_BOUNDARY_LOW, lo);
        write_reg(mbs_pkg::REG_BOUNDARY_HIGH, hi);
        gen_low  = lo;
        gen_high = hi;
        set_length(len_word);
    endtask

    // every sent byte accepted, every report received, block settled
    task wait_idle();
        while (pending_bytes.size() != 0 || body_ch.valid || expected_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [mbs_pkg::BYTE_W-1:0] bnd_char(input int i);
        logic [2*mbs_pkg::CFG_W-1:0] w;
        w = {gen_high, gen_low} >> (8 * i);
        return w[mbs_pkg::BYTE_W-1:0];
    endfunction

    // random byte biased toward the characters the scanner reacts to
    function automatic logic [mbs_pkg::BYTE_W-1:0] noise_byte();
        case ($urandom_range(0, 9))
            0: return mbs_pkg::CH_CR;
            1: return mbs_pkg::CH_LF;
            2: return mbs_pkg::CH_HY;
            3: return (gen_len > 0) ? bnd_char($urandom_range(0, gen_len - 1))
                                    : mbs_pkg::BYTE_W'($urandom_range(0, 255));
            default: return mbs_pkg::BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    task send_byte(input logic [mbs_pkg::BYTE_W-1:0] c, input logic last);
        body_beat_t nb;
        nb.data_byte = c;
        nb.last_byte = last;
        pending_bytes.insert(pending_bytes.size(), nb);
    endtask

    task add_delim_byte(input logic [mbs_pkg::BYTE_W-1:0] c);
        delim_buf.insert(delim_buf.size(), c);
    endtask

    task add_body_byte(input logic [mbs_pkg::BYTE_W-1:0] c);
        body_buf.insert(body_buf.size(), c);
    endtask

    // full delimiter into delim_buf; a leading one omits the CR LF
    task build_delim(input bit lead, input bit closing);
        delim_buf = {};
        if (!lead)
        begin
            add_delim_byte(mbs_pkg::CH_CR);
            add_delim_byte(mbs_pkg::CH_LF);
        end
        add_delim_byte(mbs_pkg::CH_HY);
        add_delim_byte(mbs_pkg::CH_HY);
        for (int i = 0; i < gen_len; i++)
            add_delim_byte(bnd_char(i));
        if (closing)
        begin
            add_delim_byte(mbs_pkg::CH_HY);
            add_delim_byte(mbs_pkg::CH_HY);
        end
        add_delim_byte(mbs_pkg::CH_CR);
        add_delim_byte(mbs_pkg::CH_LF);
    endtask

    task append_delim(input int keep);
        for (int i = 0; i < keep && i < delim_buf.size(); i++)
            add_body_byte(delim_buf[i]);
    endtask

    // one random body built from delimiters, broken delimiters and noise
    task queue_body(input int segs);
        int cut;
        bit closing;
        body_buf = {};
        if ($urandom_range(0, 3) == 0)
        begin
            build_delim(1'b1, $urandom_range(0, 1));
            append_delim(delim_buf.size());
        end
        repeat (segs)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                    repeat ($urandom_range(1, 6)) add_body_byte(noise_byte());
                2, 3, 4:
                begin
                    build_delim(1'b0, 1'b0);
                    append_delim(delim_buf.size());
                end
                5:
                begin
                    build_delim(1'b0, 1'b1);
                    append_delim(delim_buf.size());
                end
                6, 7:
                begin
                    // broken delimiter: truncated, maybe with one byte corrupted
                    build_delim(1'b0, $urandom_range(0, 1));
                    cut = $urandom_range(1, delim_buf.size() - 1);
                    if ($urandom_range(0, 1))
                        delim_buf[$urandom_range(0, cut - 1)] = noise_byte();
                    append_delim(cut);
                end
                8:
                begin
                    // CR right after CR LF opens a new candidate
                    add_body_byte(mbs_pkg::CH_CR);
                    add_body_byte(mbs_pkg::CH_LF);
                    add_body_byte(mbs_pkg::CH_CR);
                end
                default:
                begin
                    build_delim(1'b1, $urandom_range(0, 1));
                    append_delim(delim_buf.size());
                end
            endcase
        end
        // body ending
        case ($urandom_range(0, 3))
            0:
            begin
                closing = $urandom_range(0, 1);
                build_delim(1'b0, closing);
                append_delim(delim_buf.size() - (closing ? $urandom_range(1, 3) : 1));
            end
            1: ;
            default:
                repeat ($urandom_range(1, 3)) add_body_byte(noise_byte());
        endcase
        if (body_buf.size() == 0)
            add_body_byte(noise_byte());
        foreach (body_buf[i])
            send_byte(body_buf[i], i == body_buf.size() - 1);
    endtask

    task run_phase(input int idle_pct, input int stall_pct);
        int goal;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        goal = byte_count + pending_bytes.size() + PHASE_BYTES;
        while (byte_count + pending_bytes.size() < goal)
        begin
            queue_body($urandom_range(0, 4));
            wait (pending_bytes.size() < 64);
        end
        wait_idle();
    endtask

    // drive everything to known values from the start
    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = mbs_pkg::REG_BOUNDARY_LOW;
        cfg_data          = '0;
        body_ch.valid     = 1'b0;
        body_ch.data_byte = '0;
        body_ch.last_byte = 1'b0;
        res_ch.ready      = 1'b0;
    end

    // main sequence
    initial
    begin
        int waited;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: boundary "bc"
        set_boundary(64'h6362, 64'h0, 64'd2);
        // leading hyphen, part delimiter, then a plain end
        send_byte(mbs_pkg::CH_HY, 1'b0);
        send_byte(mbs_pkg::CH_HY, 1'b0);
        send_byte(8'h62, 1'b0);
        send_byte(8'h63, 1'b0);
        send_byte(mbs_pkg::CH_CR, 1'b0);
        send_byte(mbs_pkg::CH_LF, 1'b0);
        send_byte(8'hff, 1'b1);
        // CR after CR LF, then a closing delimiter cut off after its hyphens
        send_byte(8'h00, 1'b0);
        send_byte(mbs_pkg::CH_CR, 1'b0);
        send_byte(mbs_pkg::CH_LF, 1'b0);
        send_byte(mbs_pkg::CH_CR, 1'b0);
        send_byte(mbs_pkg::CH_LF, 1'b0);
        send_byte(mbs_pkg::CH_HY, 1'b0);
        send_byte(mbs_pkg::CH_HY, 1'b0);
        send_byte(8'h62, 1'b0);
        send_byte(8'h63, 1'b0);
        send_byte(mbs_pkg::CH_HY, 1'b0);
        send_byte(mbs_pkg::CH_HY, 1'b1);
        // length shortened under a partial boundary match
        send_byte(mbs_pkg::CH_CR, 1'b0);
        send_byte(mbs_pkg::CH_LF, 1'b0);
        send_byte(mbs_pkg::CH_HY, 1'b0);
        send_byte(mbs_pkg::CH_HY, 1'b0);
        send_byte(8'h62, 1'b0);
        wait_idle();
        set_length(64'd1);
        send_byte(8'h63, 1'b0);
        send_byte(8'h78, 1'b1);
        wait_idle();

        // random phases with several boundary settings
        set_boundary({$urandom, $urandom}, {$urandom, $urandom}, 64'd4);
        run_phase(0, 0);

        // receiver held off while the sender keeps offering one-byte bodies
        hold_go = ~hold_go;
        @(negedge clk);
        @(negedge clk);
        repeat (40) send_byte(noise_byte(), 1'b1);
        wait_idle();

        set_boundary({$urandom, $urandom}, {$urandom, $urandom}, 64'd16);
        run_phase(49, 0);

        set_boundary({$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom} | 64'h10 | 64'($urandom_range(1, 15)));
        run_phase(0, 49);

        set_boundary({64{1'b1}}, {64{1'b1}}, 64'd1);
        run_phase(7, 7);

        set_boundary(64'h0, 64'h0, 64'd0);
        run_phase(49, 0);

        // short boundary drawn from noise bytes, biased toward the special characters
        for (int i = 0; i < 8; i++)
            gen_low[8*i +: 8] = noise_byte();
        set_boundary(gen_low, {$urandom, $urandom}, 64'($urandom_range(1, 8)));
        run_phase(0, 49);

        set_boundary({$urandom, $urandom}, {$urandom, $urandom},
                     64'd31 | ({$urandom, $urandom} & ~64'h1f));
        run_phase(7, 7);

        // final drain with its own limit
        waited = 0;
        while ((pending_bytes.size() != 0 || body_ch.valid || expected_reports.size() != 0)
               && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_reports.size() != 0)
        begin
            $error("%0d delimiter reports never arrived", expected_reports.size());
            err_count++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d body bytes in %0d bodies under 8 boundary settings",
                 byte_count, body_count);
        $display("checked reports: %0d part, %0d closing, %0d without delimiter",
                 part_count, close_count, none_count);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("timeout with %0d bytes and %0d reports outstanding",
                 pending_bytes.size(), expected_reports.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### files.f
hw/rtl/mbs_pkg.sv
hw/rtl/mbs_body_if.sv
hw/rtl/mbs_result_if.sv
hw/rtl/mbs_cfg_regs.sv
hw/rtl/mbs_scan_core.sv
hw/rtl/mbs_out_queue.sv
hw/rtl/mime_boundary_scanner.sv
tb/mime_boundary_scanner_test.sv
